// ----- rtl/qrs_pkg.sv -----
// Shared constants, widths and stage record types for the quadratic root solver.
// No dependencies; every other file of the block imports this package.
package qrs_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COEF_W    = 32;
   localparam int DISC_W    = 66;               // |b|^2 + 4|a||c| < 2^65
   localparam int ROOT_W    = 34;               // floor(sqrt(D)) fits 34 bits
   localparam int DSH_W     = 2 * ROOT_W;       // discriminant padded to an even width
   localparam int SREM_W    = ROOT_W + 3;       // square root partial remainder
   localparam int MAG_W     = 34;               // |-b +/- s| < 2^34
   localparam int NUM_W     = MAG_W + FRAC_BITS; // scaled numerator, one quotient bit per step
   localparam int DEN_W     = COEF_W + 1;       // 2|a|
   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = $clog2(QDEPTH);

   localparam logic [1:0] ST_TWO    = 2'd0;
   localparam logic [1:0] ST_DOUBLE = 2'd1;
   localparam logic [1:0] ST_NONE   = 2'd2;
   localparam logic [1:0] ST_AZERO  = 2'd3;

   typedef struct packed {
      logic [1:0]        status;
      logic [DISC_W-1:0] disc;
      logic [COEF_W-1:0] a;
      logic [COEF_W-1:0] b;
   } work_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [COEF_W-1:0] a;
      logic [COEF_W-1:0] b;
      logic [DSH_W-1:0]  dsh;
      logic [ROOT_W-1:0] root;
      logic [SREM_W-1:0] rem;
   } sq_type;

   typedef struct packed {
      logic [NUM_W-1:0] mag;
      logic [NUM_W-1:0] quo;
      logic [DEN_W-1:0] rem;
      logic             neg;
   } div_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [DEN_W-1:0] den;
      div_type          p;
      div_type          m;
   } dv_type;

endpackage

// ----- rtl/qrs_front.sv -----
// Front end: accepts coefficient transactions, forms the discriminant and the status.
// Depends on qrs_pkg. Two register stages that stall together when the queue is full.
module qrs_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [qrs_pkg::COEF_W-1:0] coef_a,
   input  logic [qrs_pkg::COEF_W-1:0] coef_b,
   input  logic [qrs_pkg::COEF_W-1:0] coef_c,
   output logic                     push,
   output qrs_pkg::work_type        push_data,
   input  logic                     q_full
);
   import qrs_pkg::*;

   logic                   f1_valid_ff, f1_valid_in;
   logic [COEF_W-1:0]      f1_a_ff, f1_b_ff;
   logic [2*COEF_W-1:0]    f1_b2_ff, f1_p_ff;
   logic                   f1_sdiff_ff, f1_azero_ff;
   logic                   f2_valid_ff, f2_valid_in;
   work_type               f2_ff, f2_in;
   logic                   en;
   logic [COEF_W-1:0]      mag_a, mag_b, mag_c;
   logic [DISC_W-1:0]      q4, b2x;
   logic                   neg4ac;

   assign en       = !f2_valid_ff || !q_full;
   assign in_ready = en;
   assign push     = f2_valid_ff && !q_full;
   assign push_data = f2_ff;

   assign mag_a = coef_a[COEF_W-1] ? (~coef_a + 1'b1) : coef_a;
   assign mag_b = coef_b[COEF_W-1] ? (~coef_b + 1'b1) : coef_b;
   assign mag_c = coef_c[COEF_W-1] ? (~coef_c + 1'b1) : coef_c;
   assign f1_valid_in = in_valid;

   always_ff @(posedge clock) begin
      if (en) begin
         f1_a_ff     <= coef_a;
         f1_b_ff     <= coef_b;
         f1_b2_ff    <= mag_b * mag_b;
         f1_p_ff     <= mag_a * mag_c;
         f1_sdiff_ff <= coef_a[COEF_W-1] ^ coef_c[COEF_W-1];
         f1_azero_ff <= (coef_a == '0);
         f2_ff       <= f2_in;
      end
   end

   always_comb begin
      q4     = {f1_p_ff, 2'b00};
      b2x    = {2'b00, f1_b2_ff};
      neg4ac = f1_sdiff_ff && (f1_p_ff != '0);
      f2_in.a    = f1_a_ff;
      f2_in.b    = f1_b_ff;
      f2_in.disc = '0;
      if (f1_azero_ff) begin
         f2_in.status = ST_AZERO;
      end else if (neg4ac) begin
         f2_in.status = ST_TWO;
         f2_in.disc   = b2x + q4;
      end else if (q4 == b2x) begin
         f2_in.status = ST_DOUBLE;
      end else if (q4 > b2x) begin
         f2_in.status = ST_NONE;
      end else begin
         f2_in.status = ST_TWO;
         f2_in.disc   = b2x - q4;
      end
   end

   assign f2_valid_in = f1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (en) begin
         f1_valid_ff <= f1_valid_in;
         f2_valid_ff <= f2_valid_in;
      end
   end

endmodule

// ----- rtl/qrs_queue.sv -----
// Small register queue between the front and back ends of the solver.
// Depends on qrs_pkg for the entry type and the depth.
module qrs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  qrs_pkg::work_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output qrs_pkg::work_type pop_data
);
   import qrs_pkg::*;

   work_type            mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]     cnt_ff, cnt_in;

   assign full     = (cnt_ff == QDEPTH[QPTR_W:0]);
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- rtl/qrs_back.sv -----
// Back end: pipelined square root, two pipelined dividers and output saturation.
// Depends on qrs_pkg. One root bit or one quotient bit per stage; the pipe stalls as a whole.
module qrs_back (
   input  logic                      clock,
   input  logic                      reset,
   output logic                      pop,
   input  logic                      q_empty,
   input  qrs_pkg::work_type         pop_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [qrs_pkg::COEF_W-1:0] root_plus,
   output logic [qrs_pkg::COEF_W-1:0] root_minus,
   output logic [1:0]                status,
   output logic                      overflow
);
   import qrs_pkg::*;

   logic               en;
   logic               e_valid_ff;
   work_type           e_ff;
   logic               sq_valid_ff [ROOT_W];
   sq_type             sq_ff [ROOT_W];
   sq_type             sq_in [ROOT_W];
   logic               n_valid_ff;
   dv_type             n_ff, n_in;
   logic               dv_valid_ff [NUM_W];
   dv_type             dv_ff [NUM_W];
   dv_type             dv_in [NUM_W];
   logic               o_valid_ff;
   logic [COEF_W-1:0]  o_rp_ff, o_rp_in, o_rm_ff, o_rm_in;
   logic [1:0]         o_st_ff;
   logic               o_ovf_ff, o_ovf_in;

   function automatic sq_type sq_step(input sq_type s);
      logic [SREM_W-1:0] x;
      logic [SREM_W-1:0] trial;
      sq_type r;
      x     = {s.rem[SREM_W-3:0], s.dsh[DSH_W-1 -: 2]};
      trial = {1'b0, s.root, 2'b01};
      r     = s;
      r.dsh = {s.dsh[DSH_W-3:0], 2'b00};
      if (x >= trial) begin
         r.rem  = x - trial;
         r.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = x;
         r.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic div_type div_step(input div_type d, input logic [DEN_W-1:0] den);
      logic [DEN_W:0] x;
      div_type r;
      x     = {d.rem, d.mag[NUM_W-1]};
      r     = d;
      r.mag = {d.mag[NUM_W-2:0], 1'b0};
      if (x >= {1'b0, den}) begin
         r.rem = DEN_W'(x - {1'b0, den});
         r.quo = {d.quo[NUM_W-2:0], 1'b1};
      end else begin
         r.rem = x[DEN_W-1:0];
         r.quo = {d.quo[NUM_W-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic div_type div_seed(input logic [COEF_W-1:0] b, input logic [ROOT_W-1:0] s,
                                        input logic sub, input logic a_neg);
      logic [MAG_W+1:0] num;
      logic [MAG_W+1:0] bx;
      logic [MAG_W+1:0] sx;
      div_type r;
      bx    = {{(MAG_W+2-COEF_W){b[COEF_W-1]}}, b};
      sx    = {2'b00, s};
      num   = sub ? (-bx - sx) : (-bx + sx);
      r.neg = num[MAG_W+1] ^ a_neg;
      r.mag = {(num[MAG_W+1] ? MAG_W'(-num) : num[MAG_W-1:0]), {FRAC_BITS{1'b0}}};
      r.quo = '0;
      r.rem = '0;
      return r;
   endfunction

   assign en  = !o_valid_ff || out_ready;
   assign pop = en && !q_empty;

   always_comb begin
      sq_in[0].status = e_ff.status;
      sq_in[0].a      = e_ff.a;
      sq_in[0].b      = e_ff.b;
      sq_in[0].dsh    = {{(DSH_W-DISC_W){1'b0}}, e_ff.disc};
      sq_in[0].root   = '0;
      sq_in[0].rem    = '0;
      sq_in[0]        = sq_step(sq_in[0]);
      for (int k = 1; k < ROOT_W; k++) begin
         sq_in[k] = sq_step(sq_ff[k-1]);
      end
   end

   always_comb begin
      n_in.status = sq_ff[ROOT_W-1].status;
      n_in.den    = {(sq_ff[ROOT_W-1].a[COEF_W-1] ? (~sq_ff[ROOT_W-1].a + 1'b1)
                                                  : sq_ff[ROOT_W-1].a), 1'b0};
      n_in.p      = div_seed(sq_ff[ROOT_W-1].b, sq_ff[ROOT_W-1].root, 1'b0,
                             sq_ff[ROOT_W-1].a[COEF_W-1]);
      n_in.m      = div_seed(sq_ff[ROOT_W-1].b, sq_ff[ROOT_W-1].root, 1'b1,
                             sq_ff[ROOT_W-1].a[COEF_W-1]);
   end

   always_comb begin
      dv_in[0]   = n_ff;
      dv_in[0].p = div_step(n_ff.p, n_ff.den);
      dv_in[0].m = div_step(n_ff.m, n_ff.den);
      for (int k = 1; k < NUM_W; k++) begin
         dv_in[k]   = dv_ff[k-1];
         dv_in[k].p = div_step(dv_ff[k-1].p, dv_ff[k-1].den);
         dv_in[k].m = div_step(dv_ff[k-1].m, dv_ff[k-1].den);
      end
   end

   always_comb begin
      logic [NUM_W-1:0] qp;
      logic [NUM_W-1:0] qm;
      logic             ovp;
      logic             ovm;
      qp = dv_ff[NUM_W-1].p.quo;
      qm = dv_ff[NUM_W-1].m.quo;
      if (dv_ff[NUM_W-1].p.neg) begin
         ovp     = (qp[NUM_W-1:COEF_W] != '0) || (qp[COEF_W-1] && (qp[COEF_W-2:0] != '0));
         o_rp_in = ovp ? {1'b1, {(COEF_W-1){1'b0}}} : (~qp[COEF_W-1:0] + 1'b1);
      end else begin
         ovp     = (qp[NUM_W-1:COEF_W-1] != '0);
         o_rp_in = ovp ? {1'b0, {(COEF_W-1){1'b1}}} : qp[COEF_W-1:0];
      end
      if (dv_ff[NUM_W-1].m.neg) begin
         ovm     = (qm[NUM_W-1:COEF_W] != '0) || (qm[COEF_W-1] && (qm[COEF_W-2:0] != '0));
         o_rm_in = ovm ? {1'b1, {(COEF_W-1){1'b0}}} : (~qm[COEF_W-1:0] + 1'b1);
      end else begin
         ovm     = (qm[NUM_W-1:COEF_W-1] != '0);
         o_rm_in = ovm ? {1'b0, {(COEF_W-1){1'b1}}} : qm[COEF_W-1:0];
      end
      o_ovf_in = ovp || ovm;
      if (dv_ff[NUM_W-1].status == ST_NONE || dv_ff[NUM_W-1].status == ST_AZERO) begin
         o_rp_in  = '0;
         o_rm_in  = '0;
         o_ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff <= pop_data;
         for (int k = 0; k < ROOT_W; k++) begin
            sq_ff[k] <= sq_in[k];
         end
         n_ff <= n_in;
         for (int k = 0; k < NUM_W; k++) begin
            dv_ff[k] <= dv_in[k];
         end
         o_rp_ff  <= o_rp_in;
         o_rm_ff  <= o_rm_in;
         o_st_ff  <= dv_ff[NUM_W-1].status;
         o_ovf_ff <= o_ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         for (int k = 0; k < ROOT_W; k++) begin
            sq_valid_ff[k] <= 1'b0;
         end
         n_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_W; k++) begin
            dv_valid_ff[k] <= 1'b0;
         end
         o_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff     <= !q_empty;
         sq_valid_ff[0] <= e_valid_ff;
         for (int k = 1; k < ROOT_W; k++) begin
            sq_valid_ff[k] <= sq_valid_ff[k-1];
         end
         n_valid_ff     <= sq_valid_ff[ROOT_W-1];
         dv_valid_ff[0] <= n_valid_ff;
         for (int k = 1; k < NUM_W; k++) begin
            dv_valid_ff[k] <= dv_valid_ff[k-1];
         end
         o_valid_ff <= dv_valid_ff[NUM_W-1];
      end
   end

   assign out_valid  = o_valid_ff;
   assign root_plus  = o_rp_ff;
   assign root_minus = o_rm_ff;
   assign status     = o_st_ff;
   assign overflow   = o_ovf_ff;

endmodule

// ----- rtl/quadratic_root_solver_unit.sv -----
// Top level of the quadratic root solver: front end, queue and back end.
// Depends on qrs_pkg, qrs_front, qrs_queue and qrs_back.
//
// Usage: each transaction on the req_ channel carries the coefficients a, b and c of
// a*x*x + b*x + c = 0 as signed Q16.16 values. Each one yields exactly one transaction
// on the rsp_ channel with both real roots (Q16.16, truncated toward zero, saturated)
// in rsp_tdata, and the status code and the overflow flag in rsp_tuser. Items are
// independent.
// Throughput: one transaction per cycle when the receiver keeps rsp_tready high.
// Pipeline: the first front-end register (multiply) loads at the accepting edge, then
// the second (classify), the queue entry, 1 entry stage, 34 square root stages (one
// root bit each), 1 numerator stage, 50 divider stages (one quotient bit each, both
// roots side by side) and the output register, which drives rsp_tvalid. The bit-serial
// square root and division pipelines make up most of this path.
// Stalls: when rsp_tvalid is high and rsp_tready low the back end holds; the four-entry queue then keeps
// absorbing front-end results until it fills, after which req_tready drops.
// Reset: synchronous and active high; it empties every stage and the queue, so no
// transaction is in flight afterwards.
module quadratic_root_solver_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // coef_a [31:0], coef_b [63:32], coef_c [95:64]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // root_plus [31:0], root_minus [63:32]
   output logic [2:0]  rsp_tuser    // status [1:0], overflow [2]
);
   import qrs_pkg::*;

   logic              push, q_full, pop, q_empty;
   work_type          push_data, pop_data;
   logic [COEF_W-1:0] root_plus, root_minus;
   logic [1:0]        status;
   logic              overflow;

   qrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .coef_a    (req_tdata[31:0]),
      .coef_b    (req_tdata[63:32]),
      .coef_c    (req_tdata[95:64]),
      .push      (push),
      .push_data (push_data),
      .q_full    (q_full)
   );

   qrs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .empty     (q_empty),
      .pop_data  (pop_data)
   );

   qrs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop        (pop),
      .q_empty    (q_empty),
      .pop_data   (pop_data),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .root_plus  (root_plus),
      .root_minus (root_minus),
      .status     (status),
      .overflow   (overflow)
   );

   assign rsp_tdata = {root_minus, root_plus};
   assign rsp_tuser = {overflow, status};

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for quadratic_root_solver_unit: directed and random coefficient sets.
// Depends on qrs_pkg and the RTL; it predicts every result in SystemVerilog and checks in order.
`timescale 1ns / 1ps

module tb_top;
   import qrs_pkg::*;

   typedef struct packed {
      logic [31:0] root_plus;
      logic [31:0] root_minus;
      logic [1:0]  status;
      logic        overflow;
   } roots_type;

   localparam int IDLE_LIMIT = 4000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   roots_type   expected_roots[$];
   int          error_count;
   int          idle_cycles;
   bit          quiet;         // when set, neither side idles

   quadratic_root_solver_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Scaled quotient (num * 2^16) / (2a), truncated toward zero and saturated.
   function automatic logic [31:0] scaled_quotient(logic signed [63:0] num,
                                                   logic signed [31:0] a, ref bit ovf);
      logic signed [63:0] a_wide;
      logic [63:0]        mag;
      logic [63:0]        den;
      logic [63:0]        quo;
      bit                 neg;
      a_wide = a;
      mag    = (num < 0 ? -num : num) << FRAC_BITS;
      den    = (a_wide < 0 ? -a_wide : a_wide) << 1;
      quo    = mag / den;
      neg    = (num < 0) != (a < 0);
      if (!neg) begin
         if (quo > 64'h7FFF_FFFF) begin
            ovf = 1'b1;
            quo = 64'h7FFF_FFFF;
         end
         return quo[31:0];
      end
      if (quo > 64'h8000_0000) begin
         ovf = 1'b1;
         quo = 64'h8000_0000;
      end
      return 32'(64'd0 - quo);
   endfunction

   function automatic roots_type solve_roots(logic signed [31:0] a, logic signed [31:0] b,
                                             logic signed [31:0] c);
      roots_type          r;
      logic signed [69:0] aw, bw, cw, disc;
      logic [69:0]        disc_u;
      logic [33:0]        root, trial;
      logic signed [63:0] b64, s64;
      bit                 ovf;
      r    = '0;
      ovf  = 1'b0;
      root = '0;
      aw   = a;
      bw   = b;
      cw   = c;
      b64  = b;
      if (a == 0) begin
         r.status = ST_AZERO;
         return r;
      end
      disc = bw * bw - 70'sd4 * aw * cw;
      if (disc < 0) begin
         r.status = ST_NONE;
      end else if (disc == 0) begin
         r.status     = ST_DOUBLE;
         r.root_plus  = scaled_quotient(-b64, a, ovf);
         r.root_minus = r.root_plus;
      end else begin
         r.status = ST_TWO;
         disc_u   = disc;
         for (int i = 33; i >= 0; i--) begin
            trial = root | (34'd1 << i);
            if ({36'd0, trial} * {36'd0, trial} <= disc_u) root = trial;
         end
         s64          = signed'({30'd0, root});
         r.root_plus  = scaled_quotient(-b64 + s64, a, ovf);
         r.root_minus = scaled_quotient(-b64 - s64, a, ovf);
      end
      r.overflow = ovf;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Drives one coefficient set and records its prediction once it is accepted.
   task automatic send_coefs(logic [31:0] a, logic [31:0] b, logic [31:0] c);
      if (!quiet && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {c, b, a};
      do @(posedge clock); while (!req_tready);
      expected_roots.push_back(solve_roots(a, b, c));
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
   endtask

   // Coefficients built from two chosen roots so that real roots are common.
   task automatic send_from_roots();
      logic signed [31:0] a, r1, r2;
      logic signed [63:0] b, c;
      a  = $signed($urandom_range(2048, 1)) * ($urandom_range(1) ? 1 : -1);
      r1 = $signed($urandom_range(4096)) - 2048;
      r2 = $urandom_range(3) == 0 ? r1 : $signed($urandom_range(4096)) - 2048;
      b  = -(64'(a) * (64'(r1) + 64'(r2)));
      c  = 64'(a) * 64'(r1) * 64'(r2);
      send_coefs(a << 8, 32'(b << 8), 32'(c << 8));
   endtask

   task automatic test_directed();
      logic [31:0] extremes[6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                                   32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000};
      send_coefs(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000);  // two roots: 2 and 1
      send_coefs(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000);  // double root at 1
      send_coefs(32'h0001_0000, 32'h0000_0000, 32'h0001_0000);  // no real roots
      send_coefs(32'h0000_0000, 32'h0005_0000, 32'h0001_0000);  // a is zero
      send_coefs(32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_0000);  // saturating root
      send_coefs(32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF);  // tiny positive disc
      send_coefs(32'hFFFF_0000, 32'h0000_0000, 32'h0001_0000);  // negative a
      for (int i = 0; i < 6; i += 2)
         for (int j = 0; j < 6; j += 3)
            send_coefs(extremes[i + 1], extremes[j], extremes[5 - i]);
      send_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_coefs(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      end_burst();
   endtask

   task automatic test_random_mix(int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(9);
         if (pick < 5) send_from_roots();
         else if (pick < 8) send_coefs($urandom, $urandom, $urandom);
         else if (pick == 8) send_coefs(32'd0, $urandom, $urandom);
         else send_coefs($urandom_range(255) << 16, $urandom_range(255) << 16,
                         $urandom_range(255) << 16);
      end
      end_burst();
   endtask

   // Back to back with no idling on either side.
   task automatic test_full_rate(int count);
      quiet = 1'b1;
      test_random_mix(count);
      quiet = 1'b0;
   endtask

   // The sender holds off until every outstanding result is back.
   task automatic test_drain_pause();
      test_random_mix(20);
      while (expected_roots.size() != 0) @(posedge clock);
      test_random_mix(20);
   endtask

   // Receiver back-pressure, redrawn every cycle.
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 7);
   end

   // Result checker: each response is compared with the oldest prediction.
   always @(posedge clock) begin
      roots_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_roots.size() == 0) begin
            $display("unexpected response %h %h at %0t", rsp_tuser, rsp_tdata, $realtime);
            error_count++;
         end else begin
            want = expected_roots.pop_front();
            if (rsp_tdata[31:0] !== want.root_plus)
               report_mismatch("root_plus", rsp_tdata[31:0], want.root_plus);
            if (rsp_tdata[63:32] !== want.root_minus)
               report_mismatch("root_minus", rsp_tdata[63:32], want.root_minus);
            if (rsp_tuser[1:0] !== want.status)
               report_mismatch("status", rsp_tuser[1:0], want.status);
            if (rsp_tuser[2] !== want.overflow)
               report_mismatch("overflow", rsp_tuser[2], want.overflow);
         end
      end
   end

   // Watchdog on cycles in which neither channel completes a transaction.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      quiet       = 1'b0;
      error_count = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_mix(900);
      test_full_rate(400);
      test_drain_pause();
      test_random_mix(560);

      while (expected_roots.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
